@@ hdl/u16u8_pkg.sv @@
// shared types, constants and code ranges for the utf-16 to utf-8 encoder
package u16u8_pkg;

  // default depth of the work queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // utf-16 surrogate ranges and utf-8 length limits
  localparam logic [31:0] HIGH_FIRST = 32'h0000_D800;
  localparam logic [31:0] HIGH_LAST  = 32'h0000_DBFF;
  localparam logic [31:0] LOW_FIRST  = 32'h0000_DC00;
  localparam logic [31:0] LOW_LAST   = 32'h0000_DFFF;
  localparam logic [31:0] LIMIT_1    = 32'h0000_0080;
  localparam logic [31:0] LIMIT_2    = 32'h0000_0800;
  localparam logic [31:0] LIMIT_3    = 32'h0001_0000;
  localparam logic [31:0] LIMIT_4    = 32'h0020_0000;

  localparam logic [20:0] SUPP_BASE  = 21'h01_0000;

  // utf-8 lead and continuation prefixes
  localparam logic [7:0] LEAD_2    = 8'b1100_0000;
  localparam logic [7:0] LEAD_3    = 8'b1110_0000;
  localparam logic [7:0] LEAD_4    = 8'b1111_0000;
  localparam logic [7:0] CONT_MARK = 8'b1000_0000;

  // number of utf-8 bytes minus one
  typedef enum logic [1:0] {
    LEN_1,
    LEN_2,
    LEN_3,
    LEN_4
  } seq_len_t;

  // one classified unit of work for the byte emitter
  typedef struct packed {
    logic [20:0] cp;      // code point to encode
    seq_len_t    len;     // byte count minus one
    logic        marker;  // no byte, flags only
    logic        err;     // invalid input seen
    logic        eos;     // item closed the string
  } work_t;

endpackage

@@ hdl/utf16_to_utf8_encoder.sv @@
// top level of the utf-16 / wide character to utf-8 encoder
//
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------
// unit in   | unit_valid / unit_stall | code_unit[31:0], end_of_string
// utf8 out  | utf8_valid / utf8_stall | out_byte[7:0], byte_valid, last_of_char,
//           |                         | error, string_end
//
// each word in is taken while the work queue is not full; the classifier joins surrogate pairs and
// queues one work entry per word that gives any result
// the emitter sends one byte per cycle unless utf8_stall holds it, so a word costs 1 to 4
// output words; the output register bounds the sustained rate at that byte count
// words that give no result (held high surrogate, dropped after error) are taken
// on the input side and cost nothing on the output side
// unit_stall rises only when the work queue is full; utf8_stall holds the
// output register and backs the queue up
// synchronous reset clears surrogate and error state, the queue and the
// output valid
module utf16_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_valid,
  output logic        unit_stall,
  input  logic [31:0] code_unit,
  input  logic        end_of_string,
  output logic        utf8_valid,
  input  logic        utf8_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_char,
  output logic        error,
  output logic        string_end
);
  import u16u8_pkg::*;

  // front to queue
  logic  push;
  work_t push_item;
  logic  q_full;

  // queue to back
  logic  pop;
  logic  not_empty;
  work_t head;

  // classify words, hold high surrogates, track the error state
  u16u8_front u_front (
    .clk           (clk),
    .rst           (rst),
    .unit_valid    (unit_valid),
    .unit_stall    (unit_stall),
    .code_unit     (code_unit),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // decouples input acceptance from byte emission
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // one utf-8 byte or marker per cycle into the output register unless utf8_stall holds it
  u16u8_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (not_empty),
    .head         (head),
    .pop          (pop),
    .utf8_valid   (utf8_valid),
    .utf8_stall   (utf8_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last_of_char (last_of_char),
    .error        (error),
    .string_end   (string_end)
  );

endmodule

@@ hdl/u16u8_front.sv @@
// front end: accepts code units, joins surrogates, classifies and tracks errors
module u16u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_stall,
  input  logic [31:0]       code_unit,
  input  logic              end_of_string,
  input  logic              q_full,
  output logic              push,
  output u16u8_pkg::work_t  push_item
);
  import u16u8_pkg::*;

  logic       pending_high;
  logic       pending_high_next;
  logic [9:0] high_offset;
  logic [9:0] high_offset_next;
  logic       error_seen;
  logic       error_seen_next;

  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       do_err;
  logic       do_enc;
  logic       do_mark;
  logic       emit;
  logic [20:0] cp;
  seq_len_t   len;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;

  assign is_high = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
  assign is_low  = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);

  always_comb begin
    pending_high_next = pending_high;
    high_offset_next  = high_offset;
    error_seen_next   = error_seen;
    do_err  = 1'b0;
    do_enc  = 1'b0;
    do_mark = 1'b0;
    cp      = code_unit[20:0];
    len     = LEN_1;

    if (error_seen) begin
      // rest of the string is dropped, only the end gets a marker
      do_mark = end_of_string;
    end else if (pending_high) begin
      pending_high_next = 1'b0;
      high_offset_next  = '0;
      if (is_low) begin
        cp     = SUPP_BASE + {1'b0, high_offset, code_unit[9:0]};
        len    = LEN_4;
        do_enc = 1'b1;
      end else begin
        do_err = 1'b1;
      end
    end else if (is_high) begin
      if (end_of_string) begin
        do_mark = 1'b1;
      end else begin
        pending_high_next = 1'b1;
        high_offset_next  = code_unit[9:0];
      end
    end else if (is_low) begin
      do_err = 1'b1;
    end else if (code_unit < LIMIT_1) begin
      do_enc = 1'b1;
      len    = LEN_1;
    end else if (code_unit < LIMIT_2) begin
      do_enc = 1'b1;
      len    = LEN_2;
    end else if (code_unit < LIMIT_3) begin
      do_enc = 1'b1;
      len    = LEN_3;
    end else if (code_unit < LIMIT_4) begin
      do_enc = 1'b1;
      len    = LEN_4;
    end else begin
      do_err = 1'b1;
    end

    if (do_err) begin
      error_seen_next = 1'b1;
    end

    // end of string always starts clean
    if (end_of_string) begin
      pending_high_next = 1'b0;
      high_offset_next  = '0;
      error_seen_next   = 1'b0;
    end

    push_item        = '0;
    push_item.cp     = do_enc ? cp : '0;
    push_item.len    = do_enc ? len : LEN_1;
    push_item.marker = !do_enc;
    push_item.err    = do_err;
    push_item.eos    = end_of_string;

    emit = do_err || do_enc || do_mark;
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high <= 1'b0;
      high_offset  <= '0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      pending_high <= pending_high_next;
      high_offset  <= high_offset_next;
      error_seen   <= error_seen_next;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> !pending_high && !error_seen)
    else $error("state not cleared after end of string");

  a_pending_no_err: assert property (@(posedge clk) disable iff (rst)
    pending_high |-> !error_seen)
    else $error("high surrogate held while string is in error");

endmodule

@@ hdl/u16u8_queue.sv @@
// short work queue between classifier and byte emitter
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u16u8_pkg::work_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output u16u8_pkg::work_t  head
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("pop from empty queue");

endmodule

@@ hdl/u16u8_back.sv @@
// back end: serializes one queued item into utf-8 bytes, one per cycle while not stalled
module u16u8_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  u16u8_pkg::work_t  head,
  output logic              pop,
  output logic              utf8_valid,
  input  logic              utf8_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              last_of_char,
  output logic              error,
  output logic              string_end
);
  import u16u8_pkg::*;

  logic [1:0] idx;
  logic [1:0] pos;
  logic       load;
  logic       last;
  logic [7:0] lead;
  logic [5:0] six;
  logic [7:0] byte_next;

  assign load = head_valid && (!utf8_valid || !utf8_stall);
  assign last = (idx == 2'(head.len));
  assign pop  = load && last;
  assign pos  = 2'(head.len) - idx;

  always_comb begin
    unique case (head.len)
      LEN_1:   lead = {1'b0, head.cp[6:0]};
      LEN_2:   lead = LEAD_2 | {3'b000, head.cp[10:6]};
      LEN_3:   lead = LEAD_3 | {4'b0000, head.cp[15:12]};
      LEN_4:   lead = LEAD_4 | {5'b00000, head.cp[20:18]};
      default: lead = '0;
    endcase

    case (pos)
      2'd0:    six = head.cp[5:0];
      2'd1:    six = head.cp[11:6];
      2'd2:    six = head.cp[17:12];
      default: six = '0;
    endcase

    if (head.marker) begin
      byte_next = '0;
    end else if (idx == '0) begin
      byte_next = lead;
    end else begin
      byte_next = CONT_MARK | {2'b00, six};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      utf8_valid <= 1'b0;
    end else begin
      if (pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
      if (load) begin
        utf8_valid <= 1'b1;
      end else if (!utf8_stall) begin
        utf8_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= byte_next;
      byte_valid   <= !head.marker;
      last_of_char <= last;
      error        <= head.err;
      string_end   <= last && head.eos;
    end
  end

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.marker |-> head.len == LEN_1)
    else $error("marker item with more than one result");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    utf8_valid && !byte_valid |-> last_of_char)
    else $error("marker result not last of its item");

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the utf-16 to utf-8 encoder
`timescale 1ns / 1ps

// one expected or observed utf-8 output word
typedef struct packed {
  logic [7:0] data;
  logic       has_byte;
  logic       last;
  logic       err;
  logic       fin;
} utf8_result_t;

// predicts the utf-8 words for each accepted unit and checks them in order
class utf8_scoreboard;
  localparam logic [31:0] HI_FIRST = 32'h0000_D800;
  localparam logic [31:0] HI_LAST  = 32'h0000_DBFF;
  localparam logic [31:0] LO_FIRST = 32'h0000_DC00;
  localparam logic [31:0] LO_LAST  = 32'h0000_DFFF;
  localparam logic [31:0] SUPP_ORG = 32'h0001_0000;
  localparam logic [31:0] CP_LIMIT = 32'h0020_0000;

  utf8_result_t bytes_due[$];
  bit          held_high;
  logic [9:0]  held_offset;
  bit          string_broken;
  int          mismatches;
  int          units_taken;
  int          bytes_seen;
  int          error_marks;
  int          strings_closed;

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function void clear_string();
    held_high     = 0;
    held_offset   = '0;
    string_broken = 0;
  endfunction

  function void push_word(logic [7:0] b, logic v, logic l, logic e, logic f);
    utf8_result_t r;
    r.data = b; r.has_byte = v; r.last = l; r.err = e; r.fin = f;
    bytes_due.push_back(r);
  endfunction

  // work out the utf-8 words caused by one accepted unit
  function void predict_bytes(logic [31:0] cu, logic eos);
    logic [31:0] cp;
    logic [7:0]  seq[4];
    bit          bad;
    int          n;
    cp  = cu;
    bad = 0;
    units_taken++;
    if (string_broken) begin
      if (eos) begin
        clear_string();
        push_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
      end
      return;
    end
    if (held_high) begin
      held_high = 0;
      if (cu >= LO_FIRST && cu <= LO_LAST)
        cp = {12'd0, held_offset, cu[9:0]} + SUPP_ORG;
      else
        bad = 1;
      held_offset = '0;
    end else if (cu >= HI_FIRST && cu <= HI_LAST) begin
      if (eos) begin
        clear_string();
        push_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        return;
      end
      held_high   = 1;
      held_offset = cu[9:0];
      return;
    end else if (cu >= LO_FIRST && cu <= LO_LAST) begin
      bad = 1;
    end
    if (!bad && cp >= CP_LIMIT) bad = 1;
    if (bad) begin
      if (eos) clear_string();
      else string_broken = 1;
      push_word(8'h00, 1'b0, 1'b1, 1'b1, eos);
      return;
    end
    if (cp < 32'h80) begin
      n = 1;
      seq[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      n = 2;
      seq[0] = 8'hC0 | {3'b000, cp[10:6]};
      seq[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp < SUPP_ORG) begin
      n = 3;
      seq[0] = 8'hE0 | {4'b0000, cp[15:12]};
      seq[1] = 8'h80 | {2'b00, cp[11:6]};
      seq[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      n = 4;
      seq[0] = 8'hF0 | {5'b00000, cp[20:18]};
      seq[1] = 8'h80 | {2'b00, cp[17:12]};
      seq[2] = 8'h80 | {2'b00, cp[11:6]};
      seq[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    for (int i = 0; i < n; i++)
      push_word(seq[i], 1'b1, i == n - 1, 1'b0, (i == n - 1) && eos);
    if (eos) clear_string();
  endfunction

  task check_byte(utf8_result_t got);
    utf8_result_t want;
    bytes_seen++;
    if (got.err) error_marks++;
    if (got.fin) strings_closed++;
    if (bytes_due.size() == 0) begin
      report($sformatf("unexpected word byte=%h valid=%b", got.data, got.has_byte));
      return;
    end
    want = bytes_due.pop_front();
    if (got.data !== want.data)
      report($sformatf("out_byte %h, want %h", got.data, want.data));
    if (got.has_byte !== want.has_byte)
      report($sformatf("byte_valid %b, want %b", got.has_byte, want.has_byte));
    if (got.last !== want.last)
      report($sformatf("last_of_char %b, want %b", got.last, want.last));
    if (got.err !== want.err)
      report($sformatf("error %b, want %b", got.err, want.err));
    if (got.fin !== want.fin)
      report($sformatf("string_end %b, want %b", got.fin, want.fin));
  endtask

  task flush_leftover();
    utf8_result_t want;
    while (bytes_due.size() > 0) begin
      want = bytes_due.pop_front();
      report($sformatf("missing word byte=%h valid=%b", want.data, want.has_byte));
    end
  endtask
endclass

module testbench;
  // random stimulus size and run bounds
  localparam int RANDOM_UNITS = 234;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        unit_valid;
  logic        unit_stall;
  logic [31:0] code_unit;
  logic        end_of_string;
  logic        utf8_valid;
  logic        utf8_stall;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_of_char;
  logic        error;
  logic        string_end;

  // calm: no idling on either side; hold_pending: receiver takes one long break
  logic calm         = 1'b0;
  logic hold_pending = 1'b0;
  int   units_sent;

  utf8_scoreboard tally = new();

  utf16_to_utf8_encoder u_top (
    .clk           (clk),
    .rst           (rst),
    .unit_valid    (unit_valid),
    .unit_stall    (unit_stall),
    .code_unit     (code_unit),
    .end_of_string (end_of_string),
    .utf8_valid    (utf8_valid),
    .utf8_stall    (utf8_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last_of_char  (last_of_char),
    .error         (error),
    .string_end    (string_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one word and wait until the block takes it; valid stays high
  // afterwards so back-to-back words need no extra assignment
  task automatic send_word(input logic [31:0] cu, input logic eos);
    while (!calm && $urandom_range(0, 99) < 23) begin
      unit_valid <= 1'b0;
      @(posedge clk);
    end
    unit_valid    <= 1'b1;
    code_unit     <= cu;
    end_of_string <= eos;
    @(posedge clk);
    while (unit_stall) @(posedge clk);
    // accepted at this edge
    tally.predict_bytes(cu, eos);
    units_sent++;
  endtask

  // legal units of every utf-8 length; surrogates kept out of the bmp draw
  function automatic logic [31:0] plain_unit();
    int pick;
    logic [31:0] u;
    pick = $urandom_range(0, 99);
    if (pick < 30) u = $urandom_range(0, 32'h7F);
    else if (pick < 55) u = $urandom_range(32'h80, 32'h7FF);
    else if (pick < 80) begin
      u = $urandom_range(32'h800, 32'hF7FF);
      if (u >= 32'hD800) u = u + 32'h0800;
    end else u = $urandom_range(32'h1_0000, 32'h1F_FFFF);
    return u;
  endfunction

  // edges of every length, surrogate handling and all error kinds
  task automatic run_directed();
    send_word(32'h0000_0000, 1'b0);   // zero unit is a real byte
    send_word(32'h0000_007F, 1'b0);
    send_word(32'h0000_0080, 1'b0);
    send_word(32'h0000_07FF, 1'b0);
    send_word(32'h0000_0800, 1'b0);
    send_word(32'h0000_D7FF, 1'b0);
    send_word(32'h0000_E000, 1'b0);
    send_word(32'h0000_FFFF, 1'b1);
    send_word(32'h0001_0000, 1'b0);
    send_word(32'h001F_FFFF, 1'b1);
    // lowest and highest surrogate pairs
    send_word(32'h0000_D800, 1'b0);
    send_word(32'h0000_DC00, 1'b0);
    send_word(32'h0000_DBFF, 1'b0);
    send_word(32'h0000_DFFF, 1'b1);
    // lone low surrogate, then dropped words until the end mark
    send_word(32'h0000_DC00, 1'b0);
    send_word(32'h0000_0041, 1'b0);
    send_word(32'h0000_0042, 1'b1);
    // high surrogate followed by a plain unit
    send_word(32'h0000_D800, 1'b0);
    send_word(32'h0000_0041, 1'b0);
    send_word(32'h0000_D800, 1'b1);
    // trailing high surrogate on its own
    send_word(32'h0000_DBFF, 1'b1);
    // out-of-range values with and without the end mark
    send_word(32'h0020_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    // high surrogate followed by another high surrogate that ends the string
    send_word(32'h0000_D800, 1'b0);
    send_word(32'h0000_DAAA, 1'b1);
  endtask

  // mostly well-formed strings; some carry one broken spot or raw noise
  task automatic run_random();
    int len;
    int bad_at;
    int kind;
    logic eos;
    logic [31:0] pair_cp;
    while (units_sent < RANDOM_UNITS + 26) begin
      len    = $urandom_range(1, 8);
      bad_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, len - 1) : -1;
      for (int k = 0; k < len; k++) begin
        eos = (k == len - 1);
        // a quiet stretch, then one long receiver break with input still offered
        if (units_sent >= 110 && units_sent < 170) calm <= 1'b1;
        else calm <= 1'b0;
        if (units_sent >= 210 && !hold_pending) hold_pending <= 1'b1;
        if (k == bad_at) begin
          kind = $urandom_range(0, 3);
          case (kind)
            0: send_word($urandom_range(32'hDC00, 32'hDFFF), eos);
            1: send_word($urandom_range(32'h20_0000, 32'hFFFF_FFFF), eos);
            2: begin
              send_word($urandom_range(32'hD800, 32'hDBFF), 1'b0);
              send_word(plain_unit(), eos);
            end
            default: send_word($urandom_range(32'hD800, 32'hDBFF), eos);
          endcase
        end else if ($urandom_range(0, 99) < 5) begin
          send_word($urandom(), eos);
        end else if ($urandom_range(0, 99) < 22) begin
          // supplementary code point sent as a surrogate pair
          pair_cp = $urandom_range(0, 32'hF_FFFF);
          send_word(32'hD800 | {22'd0, pair_cp[19:10]}, 1'b0);
          send_word(32'hDC00 | {22'd0, pair_cp[9:0]}, eos);
        end else begin
          send_word(plain_unit(), eos);
        end
      end
    end
  endtask

  // receiver: random stall, quiet during calm, one long counted hold-off
  initial begin
    int held;
    bit hold_done;
    hold_done  = 0;
    utf8_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending && !hold_done) begin
        held = 0;
        while (held < HOLD_CYCLES) begin
          utf8_stall <= 1'b1;
          @(posedge clk);
          held++;
        end
        hold_done = 1;
      end
      utf8_stall <= !calm && ($urandom_range(0, 99) < 23);
    end
  end

  // output side: every accepted word is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && utf8_valid && !utf8_stall)
      tally.check_byte({out_byte, byte_valid, last_of_char, error, string_end});
  end

  // watchdog: too long without any handshake on either side ends the run
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((unit_valid && !unit_stall) || (utf8_valid && !utf8_stall)) stuck = 0;
      else stuck++;
    end
    $display("timeout after %0d cycles with no word moving", STUCK_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence: reset, directed words, random strings, drain, verdict
  initial begin
    units_sent    = 0;
    unit_valid    <= 1'b0;
    code_unit     <= '0;
    end_of_string <= 1'b0;
    rst           <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    unit_valid <= 1'b0;
    calm       <= 1'b0;
    while (tally.bytes_due.size() > 0) @(posedge clk);
    // let any stray extra word show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    tally.flush_leftover();
    $display("covered %0d units (directed edges, surrogate pairs, error strings, noise)",
             tally.units_taken);
    $display("checked %0d utf-8 words, %0d error marks, %0d string ends",
             tally.bytes_seen, tally.error_marks, tally.strings_closed);
    if (tally.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_encoder.sv
bench/testbench.sv
